// ----- rtl/core/btha_pkg.sv -----
// ----------------------------------------------------------------------------
// btha_pkg
// shared codes, widths and helpers of the boundary-tag heap allocator
// ----------------------------------------------------------------------------
package btha_pkg;

	localparam int unsigned ARENA_WORDS_DEF = 65536;

	localparam int MODE_W   = 3;
	localparam int CNT_W    = 19;
	localparam int TYPE_W   = 8;
	localparam int OFF_W    = 18;
	localparam int STAT_W   = 2;
	localparam int PSIZE_W  = 18;
	localparam int FREE_W   = 19;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 56;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC       = 3'd0,
		MODE_FREE        = 3'd1,
		MODE_SHRINK      = 3'd2,
		MODE_FREE_TYPE   = 3'd3,
		MODE_MARK_STREAM = 3'd4,
		MODE_MARK_DONE   = 3'd5,
		MODE_INSPECT     = 3'd6
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK          = 2'd0,
		STATUS_NOFIT_TOL   = 2'd1,
		STATUS_NOFIT_FATAL = 2'd2
	} status_t;

	localparam logic [1:0] BLK_FREE   = 2'd0;
	localparam logic [1:0] BLK_USED   = 2'd1;
	localparam logic [1:0] BLK_STREAM = 2'd2;

	localparam logic [TYPE_W-1:0] TYPE_TOLERATED = 8'd16;

	function automatic logic is_reloc(input logic [TYPE_W-1:0] t);
		return t == 8'd1 || t == 8'd2 || t == 8'd4 || t == 8'h2C || t == 8'h2F;
	endfunction

endpackage

// ----- rtl/core/boundary_tag_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// heap manager over a chain of block headers held in one memory
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | byte_count, block_type, payload_offset, pad | mode
//  m_*     | out | result_offset, payload_size, block_ready,   | status
//          |     | free_bytes                                  |
//
// after reset a clearing pass writes all ARENA_WORDS headers, one per cycle,
// with s_tready low
// one request at a time: alloc walks the chain for the last fit (the first one for
// relocatable types), free-by-type a scan and a free per freed block
// the header walk reads one block header per cycle from the header memory
// a finished result waits in the output register while the next request runs
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
	parameter int unsigned ARENA_WORDS = btha_pkg::ARENA_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// byte_count, block_type, payload_offset, zero pad
	input  logic [btha_pkg::S_DATA_W-1:0] s_tdata,
	// mode
	input  logic [btha_pkg::MODE_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_offset, payload_size, block_ready, free_bytes
	output logic [btha_pkg::M_DATA_W-1:0] m_tdata,
	// status
	output logic [btha_pkg::STAT_W-1:0]   m_tuser
);

	localparam int AW = $clog2(ARENA_WORDS);
	localparam int SW = $clog2(ARENA_WORDS + 1);
	localparam int CW = 22;
	localparam logic [SW:0]   A_EXT  = (SW+1)'(ARENA_WORDS);
	localparam logic [CW-1:0] A_WIDE = CW'(ARENA_WORDS);
	localparam logic [AW-1:0] LAST   = AW'(ARENA_WORDS - 1);

	typedef struct packed {
		logic                          head;
		logic [1:0]                    st;
		logic [btha_pkg::TYPE_W-1:0]   ty;
		logic [SW-1:0]                 size;
	} hdr_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_AL0, S_ALW, S_ALD, S_AL2, S_FB, S_FBC, S_SH1, S_SH2,
		S_REL, S_JRD, S_JCK, S_JWA, S_PW0, S_PW, S_RDONE, S_FT0, S_FT, S_FIN
	} state_t;

	typedef enum logic [1:0] {JR_PRED, JR_REL, JR_FIN} jret_t;

	localparam hdr_t INIT_HDR = '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0,
		size: SW'(ARENA_WORDS)};

	hdr_t hdr_mem [ARENA_WORDS];
	hdr_t rd_q;

	state_t                         state_q;
	jret_t                          jret_q;
	logic [AW-1:0]                  clr_q;
	btha_pkg::mode_t                mode_q;
	logic [btha_pkg::CNT_W-1:0]     cnt_q;
	logic [btha_pkg::TYPE_W-1:0]    typ_q;
	logic [btha_pkg::OFF_W-1:0]     off_q;
	logic [SW-1:0]                  p_q, best_q, bsize_q, w_q, wsize_q, ja_q, jsize_q;
	logic [SW-1:0]                  used_q;
	logic                           found_q;
	hdr_t                           hdr_q;
	logic [AW-1:0]                  a2_q;
	hdr_t                           d2_q;
	btha_pkg::status_t              res_status_q;
	logic [btha_pkg::OFF_W-1:0]     res_roff_q;
	logic [btha_pkg::PSIZE_W-1:0]   res_psize_q;
	logic                           res_ready_q;

	logic          wen;
	logic [AW-1:0] waddr, raddr;
	hdr_t          wdata;

	// walk and join arithmetic
	logic [SW:0]   pn, jb;
	logic [17:0]   need;
	logic [SW-1:0] need_w, rem, need2, rem2, al_hi, al_blk;
	logic          al_single, reloc;
	logic [16:0]   tw;
	logic [SW-1:0] tw_s, sh_size, nb;
	logic [CW-1:0] xw;
	logic          off_ok;
	logic [23:0]   roff_w, psize_w, free_w;

	assign pn     = {1'b0, p_q} + {1'b0, rd_q.size};
	assign jb     = {1'b0, ja_q} + {1'b0, jsize_q};
	assign need   = 18'((20'(cnt_q) + 20'd11) >> 2);
	assign reloc  = btha_pkg::is_reloc(typ_q);
	assign need_w = SW'(need);
	assign rem    = bsize_q - need_w;
	assign need2  = (rem < SW'(2)) ? bsize_q : need_w;
	assign rem2   = bsize_q - need2;
	assign al_hi  = best_q + rem2;
	assign al_single = (need2 == bsize_q);
	assign al_blk = (al_single || reloc) ? best_q : al_hi;
	assign tw      = 17'(cnt_q >> 2);
	assign tw_s    = SW'(tw);
	assign sh_size = hdr_q.size - tw_s;
	assign nb      = w_q + sh_size;
	assign xw      = CW'((off_q - 18'd8) >> 2);
	assign off_ok  = (off_q[1:0] == 2'd0) && (off_q >= 18'd8) && (xw < A_WIDE);
	assign roff_w  = (24'(al_blk) + 24'd2) << 2;
	assign psize_w = (24'(rd_q.size) << 2) - 24'd8;
	assign free_w  = 24'(SW'(ARENA_WORDS) - used_q) << 2;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		wen   = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (state_q)
			S_CLR: begin
				wen   = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? INIT_HDR : '0;
			end
			S_ALW, S_PW, S_FT: raddr = pn[AW-1:0];
			S_ALD: begin
				if (found_q) begin
					wen = 1'b1;
					if (al_single) begin
						waddr = best_q[AW-1:0];
						wdata = '{head: 1'b1, st: btha_pkg::BLK_USED, ty: typ_q,
							size: bsize_q};
					end else if (reloc) begin
						waddr = AW'(best_q + need2);
						wdata = '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0, size: rem2};
					end else begin
						waddr = al_hi[AW-1:0];
						wdata = '{head: 1'b1, st: btha_pkg::BLK_USED, ty: typ_q,
							size: need2};
					end
				end
			end
			S_AL2: begin
				wen   = 1'b1;
				waddr = a2_q;
				wdata = d2_q;
			end
			S_FB: raddr = xw[AW-1:0];
			S_FBC: begin
				if ((mode_q == btha_pkg::MODE_MARK_STREAM ||
					mode_q == btha_pkg::MODE_MARK_DONE) &&
					rd_q.head && rd_q.st != btha_pkg::BLK_FREE) begin
					wen   = 1'b1;
					waddr = w_q[AW-1:0];
					wdata = rd_q;
					wdata.st = (mode_q == btha_pkg::MODE_MARK_STREAM) ?
						btha_pkg::BLK_STREAM : btha_pkg::BLK_USED;
				end
			end
			S_SH1: begin
				wen   = 1'b1;
				waddr = w_q[AW-1:0];
				wdata = '{head: 1'b1, st: hdr_q.st, ty: hdr_q.ty, size: sh_size};
			end
			S_SH2: begin
				wen   = 1'b1;
				waddr = nb[AW-1:0];
				wdata = '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0, size: tw_s};
			end
			S_REL: begin
				wen   = 1'b1;
				waddr = w_q[AW-1:0];
				wdata = '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0, size: wsize_q};
			end
			S_JRD: raddr = jb[AW-1:0];
			S_JCK: begin
				if (rd_q.head && rd_q.st == btha_pkg::BLK_FREE) begin
					wen   = 1'b1;
					waddr = jb[AW-1:0];
					wdata = '0;
				end
			end
			S_JWA: begin
				wen   = 1'b1;
				waddr = ja_q[AW-1:0];
				wdata = '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0, size: jsize_q};
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// header memory, registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			hdr_mem[waddr] <= wdata;
		end
		rd_q <= hdr_mem[raddr];
	end

	function automatic state_t jret_next(input jret_t r);
		unique case (r)
			JR_PRED: return S_PW0;
			JR_REL:  return S_RDONE;
			default: return S_FIN;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			used_q       <= '0;
			jret_q       <= JR_FIN;
			found_q      <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			mode_q       <= btha_pkg::MODE_ALLOC;
			cnt_q        <= '0;
			typ_q        <= '0;
			off_q        <= '0;
			p_q          <= '0;
			best_q       <= '0;
			bsize_q      <= '0;
			w_q          <= '0;
			wsize_q      <= '0;
			ja_q         <= '0;
			jsize_q      <= '0;
			hdr_q        <= '0;
			a2_q         <= '0;
			d2_q         <= '0;
			res_status_q <= btha_pkg::STATUS_OK;
			res_roff_q   <= '0;
			res_psize_q  <= '0;
			res_ready_q  <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q       <= btha_pkg::mode_t'(s_tuser);
						cnt_q        <= s_tdata[18:0];
						typ_q        <= s_tdata[26:19];
						off_q        <= s_tdata[44:27];
						res_status_q <= btha_pkg::STATUS_OK;
						res_roff_q   <= '0;
						res_psize_q  <= '0;
						res_ready_q  <= 1'b0;
						unique case (btha_pkg::mode_t'(s_tuser))
							btha_pkg::MODE_ALLOC:     state_q <= S_AL0;
							btha_pkg::MODE_FREE_TYPE: state_q <= S_FT0;
							btha_pkg::MODE_FREE, btha_pkg::MODE_SHRINK,
							btha_pkg::MODE_MARK_STREAM, btha_pkg::MODE_MARK_DONE,
							btha_pkg::MODE_INSPECT:   state_q <= S_FB;
							default:                  state_q <= S_FIN;
						endcase
					end
				end
				S_AL0: begin
					p_q     <= '0;
					found_q <= 1'b0;
					state_q <= S_ALW;
				end
				S_ALW: begin
					if (rd_q.st == btha_pkg::BLK_FREE && CW'(rd_q.size) >= CW'(need)) begin
						best_q  <= p_q;
						bsize_q <= rd_q.size;
						found_q <= 1'b1;
					end
					if ((rd_q.st == btha_pkg::BLK_FREE && CW'(rd_q.size) >= CW'(need)
						&& reloc) || pn >= A_EXT) begin
						state_q <= S_ALD;
					end else begin
						p_q <= pn[SW-1:0];
					end
				end
				S_ALD: begin
					if (!found_q) begin
						res_status_q <= (typ_q == btha_pkg::TYPE_TOLERATED) ?
							btha_pkg::STATUS_NOFIT_TOL : btha_pkg::STATUS_NOFIT_FATAL;
						state_q <= S_FIN;
					end else begin
						used_q     <= used_q + need2;
						res_roff_q <= roff_w[17:0];
						a2_q       <= best_q[AW-1:0];
						if (reloc) begin
							d2_q <= '{head: 1'b1, st: btha_pkg::BLK_USED, ty: typ_q,
								size: need2};
						end else begin
							d2_q <= '{head: 1'b1, st: btha_pkg::BLK_FREE, ty: '0,
								size: rem2};
						end
						state_q <= al_single ? S_FIN : S_AL2;
					end
				end
				S_AL2: state_q <= S_FIN;
				S_FB: begin
					w_q     <= SW'(xw);
					state_q <= off_ok ? S_FBC : S_FIN;
				end
				S_FBC: begin
					hdr_q   <= rd_q;
					wsize_q <= rd_q.size;
					state_q <= S_FIN;
					unique case (mode_q)
						btha_pkg::MODE_FREE: begin
							if (rd_q.head && rd_q.st != btha_pkg::BLK_FREE) begin
								state_q <= S_REL;
							end
						end
						btha_pkg::MODE_SHRINK: begin
							if (tw >= 17'd2 && rd_q.head && rd_q.st != btha_pkg::BLK_FREE
								&& CW'(rd_q.size) >= CW'(tw) + CW'(2)) begin
								state_q <= S_SH1;
							end
						end
						btha_pkg::MODE_INSPECT: begin
							if (rd_q.head) begin
								res_psize_q <= psize_w[17:0];
								res_ready_q <= (rd_q.st == btha_pkg::BLK_USED);
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SH1: begin
					used_q  <= used_q - tw_s;
					state_q <= S_SH2;
				end
				S_SH2: begin
					ja_q    <= nb;
					jsize_q <= tw_s;
					jret_q  <= JR_FIN;
					state_q <= S_JRD;
				end
				S_REL: begin
					used_q  <= used_q - wsize_q;
					ja_q    <= w_q;
					jsize_q <= wsize_q;
					jret_q  <= JR_PRED;
					state_q <= S_JRD;
				end
				S_JRD: begin
					state_q <= (jb >= A_EXT) ? jret_next(jret_q) : S_JCK;
				end
				S_JCK: begin
					if (rd_q.head && rd_q.st == btha_pkg::BLK_FREE) begin
						jsize_q <= jsize_q + rd_q.size;
						state_q <= S_JWA;
					end else begin
						state_q <= jret_next(jret_q);
					end
				end
				S_JWA: state_q <= jret_next(jret_q);
				S_PW0: begin
					p_q     <= '0;
					state_q <= S_PW;
				end
				S_PW: begin
					if (pn == {1'b0, w_q}) begin
						if (rd_q.st == btha_pkg::BLK_FREE) begin
							ja_q    <= p_q;
							jsize_q <= rd_q.size;
							jret_q  <= JR_REL;
							state_q <= S_JRD;
						end else begin
							state_q <= S_RDONE;
						end
					end else if (pn >= A_EXT) begin
						state_q <= S_RDONE;
					end else begin
						p_q <= pn[SW-1:0];
					end
				end
				S_RDONE: begin
					state_q <= (mode_q == btha_pkg::MODE_FREE_TYPE) ? S_FT0 : S_FIN;
				end
				S_FT0: begin
					p_q     <= '0;
					state_q <= S_FT;
				end
				S_FT: begin
					if (rd_q.st == btha_pkg::BLK_USED && rd_q.ty == typ_q) begin
						w_q     <= p_q;
						wsize_q <= rd_q.size;
						state_q <= S_REL;
					end else if (pn >= A_EXT) begin
						state_q <= S_FIN;
					end else begin
						p_q <= pn[SW-1:0];
					end
				end
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {free_w[18:0], res_ready_q, res_psize_q, res_roff_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/btha_checker.sv -----
// ----------------------------------------------------------------------------
// btha_checker
// port-level checks on the heap allocator, bound into every instance of it
// ----------------------------------------------------------------------------
module btha_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [btha_pkg::M_DATA_W-1:0] m_tdata,
	input logic [btha_pkg::STAT_W-1:0]   m_tuser
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// a failed allocation returns no offset
	a_nofit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != btha_pkg::STATUS_OK |-> m_tdata[17:0] == 18'd0)
		else $error("offset given with failure status");

	// status code is never the unused value
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= btha_pkg::STATUS_NOFIT_FATAL)
		else $error("bad status code");

endmodule

bind boundary_tag_heap_allocator btha_checker u_btha_checker (.*);

// ----- bench/tb_boundary_tag_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator
// self-checking bench: a directed table of heap requests, then random alloc/
// free/shrink/free-type/mark/inspect traffic, each result compared with an
// in-bench model of the block header chain, under changing stall patterns
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator;
	import btha_pkg::*;

	localparam int unsigned AW = ARENA_WORDS_DEF;
	localparam int unsigned ARENA_BYTES = AW * 4;
	localparam int unsigned IDLE_LIMIT = 400000;
	localparam int N_RANDOM = 1130;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  cnt;
		logic [TYPE_W-1:0] typ;
		logic [OFF_W-1:0]  off;
	} heap_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [OFF_W-1:0]   roff;
		logic [PSIZE_W-1:0] psize;
		logic               rdy;
		logic [FREE_W-1:0]  free;
	} heap_res_t;

	typedef struct {
		heap_req_t r;
		bit        typed;
		heap_res_t e;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [MODE_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	bit hd[AW];
	logic [1:0] bst[AW];
	logic [7:0] bty[AW];
	int unsigned bsz[AW];
	int unsigned used_bytes;

	heap_res_t expected_q[$];
	table_row_t rows[$];
	logic [OFF_W-1:0] live_offs[$];
	int errors;
	int accepted_reqs;
	int checked_results;
	int allocs_ok;
	int no_fits;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_recv;
	int idle_cycles;

	boundary_tag_heap_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void heap_reset();
		for (int i = 0; i < AW; i++) begin
			hd[i] = 1'b0;
			bst[i] = BLK_FREE;
			bty[i] = '0;
			bsz[i] = 0;
		end
		hd[0] = 1'b1;
		bsz[0] = AW;
		used_bytes = 0;
	endfunction

	function automatic void set_head(int unsigned w, logic [1:0] st, logic [7:0] ty,
			int unsigned sz);
		hd[w] = 1'b1;
		bst[w] = st;
		bty[w] = ty;
		bsz[w] = sz;
	endfunction

	function automatic void merge_blocks(int unsigned a, int unsigned b);
		if (a >= AW || b >= AW || !hd[b])
			return;
		if (bst[a] == BLK_FREE && bst[b] == BLK_FREE) begin
			bsz[a] += bsz[b];
			hd[b] = 1'b0;
		end
	endfunction

	function automatic bit locate_block(int unsigned off, output int unsigned w);
		int unsigned x;
		w = 0;
		if ((off & 3) != 0 || off < 8)
			return 1'b0;
		x = (off - 8) >> 2;
		if (x >= AW || !hd[x])
			return 1'b0;
		w = x;
		return 1'b1;
	endfunction

	function automatic void release_block(int unsigned w);
		int unsigned p;
		p = 0;
		bst[w] = BLK_FREE;
		bty[w] = '0;
		used_bytes -= bsz[w] * 4;
		merge_blocks(w, w + bsz[w]);
		while (p < AW && bsz[p] != 0) begin
			if (p + bsz[p] == w) begin
				merge_blocks(p, w);
				break;
			end
			p += bsz[p];
		end
	endfunction

	function automatic heap_res_t heap_apply(heap_req_t q);
		heap_res_t r;
		int unsigned w, p, need, best, s, tw, nb;
		bit reloc, found, again;
		r = '0;
		w = 0;
		case (q.mode)
			MODE_ALLOC: begin
				need = (int'(q.cnt) + 11) >> 2;
				reloc = is_reloc(q.typ);
				found = 1'b0;
				best = 0;
				p = 0;
				while (p < AW && bsz[p] != 0) begin
					if (bst[p] == BLK_FREE && bsz[p] >= need) begin
						best = p;
						found = 1'b1;
						if (reloc)
							break;
					end
					p += bsz[p];
				end
				if (!found) begin
					r.status = (q.typ == TYPE_TOLERATED) ? STATUS_NOFIT_TOL : STATUS_NOFIT_FATAL;
				end else begin
					s = bsz[best];
					if (s - need < 2)
						need = s;
					if (need == s) begin
						set_head(best, BLK_USED, q.typ, s);
					end else if (reloc) begin
						set_head(best + need, BLK_FREE, '0, s - need);
						set_head(best, BLK_USED, q.typ, need);
					end else begin
						set_head(best + (s - need), BLK_USED, q.typ, need);
						set_head(best, BLK_FREE, '0, s - need);
						best += s - need;
					end
					used_bytes += need * 4;
					r.roff = OFF_W'((best + 2) * 4);
				end
			end
			MODE_FREE: begin
				if (locate_block(q.off, w) && bst[w] != BLK_FREE)
					release_block(w);
			end
			MODE_SHRINK: begin
				tw = q.cnt >> 2;
				if (tw >= 2 && locate_block(q.off, w) && bst[w] != BLK_FREE
						&& bsz[w] >= tw + 2) begin
					bsz[w] -= tw;
					used_bytes -= tw * 4;
					nb = w + bsz[w];
					set_head(nb, BLK_FREE, '0, tw);
					merge_blocks(nb, nb + tw);
				end
			end
			MODE_FREE_TYPE: begin
				again = 1'b1;
				while (again) begin
					again = 1'b0;
					p = 0;
					while (p < AW && bsz[p] != 0) begin
						if (bst[p] == BLK_USED && bty[p] == q.typ) begin
							release_block(p);
							again = 1'b1;
							break;
						end
						p += bsz[p];
					end
				end
			end
			MODE_MARK_STREAM, MODE_MARK_DONE: begin
				if (locate_block(q.off, w) && bst[w] != BLK_FREE)
					bst[w] = (q.mode == MODE_MARK_STREAM) ? BLK_STREAM : BLK_USED;
			end
			MODE_INSPECT: begin
				if (locate_block(q.off, w)) begin
					r.psize = PSIZE_W'(bsz[w] * 4 - 8);
					r.rdy = (bst[w] == BLK_USED);
				end
			end
			default: ;
		endcase
		r.free = FREE_W'(ARENA_BYTES - used_bytes);
		return r;
	endfunction

	task automatic mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch on result %0d: %s got %0d expected %0d", checked_results, field,
			got, want);
		errors++;
	endtask

	function automatic void add_row(logic [2:0] m, int unsigned c, int unsigned t,
			int unsigned o);
		table_row_t row;
		row.r = '{mode: m, cnt: CNT_W'(c), typ: TYPE_W'(t), off: OFF_W'(o)};
		row.typed = 1'b0;
		row.e = '0;
		rows.push_back(row);
	endfunction

	function automatic void add_typed(logic [2:0] m, int unsigned c, int unsigned t,
			int unsigned o, logic [1:0] st, int unsigned ro, int unsigned ps, bit rd,
			int unsigned fr);
		table_row_t row;
		row.r = '{mode: m, cnt: CNT_W'(c), typ: TYPE_W'(t), off: OFF_W'(o)};
		row.typed = 1'b1;
		row.e = '{status: st, roff: OFF_W'(ro), psize: PSIZE_W'(ps), rdy: rd,
			free: FREE_W'(fr)};
		rows.push_back(row);
	endfunction

	// send one request, predict it once accepted
	task automatic send_request(heap_req_t q, bit typed, heap_res_t want);
		heap_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, q.off, q.typ, q.cnt};
		s_tuser <= q.mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = heap_apply(q);
		expected_q.push_back(typed ? want : r);
		accepted_reqs++;
		if (q.mode == MODE_ALLOC) begin
			if (r.status == STATUS_OK) begin
				allocs_ok++;
				live_offs.push_back(r.roff);
			end else begin
				no_fits++;
			end
		end
	endtask

	function automatic heap_req_t random_request();
		heap_req_t q;
		int unsigned sel, idx;
		logic [7:0] types[7] = '{8'd1, 8'd2, 8'd4, 8'd44, 8'd47, 8'd16, 8'd9};
		q.typ = ($urandom_range(3) == 0) ? 8'($urandom) : types[$urandom_range(6)];
		q.cnt = ($urandom_range(19) == 0) ? 19'($urandom) : 19'($urandom_range(600));
		q.off = 18'($urandom);
		if (live_offs.size() != 0 && $urandom_range(9) != 0) begin
			idx = $urandom_range(live_offs.size() - 1);
			q.off = live_offs[idx];
		end else begin
			idx = 0;
		end
		sel = $urandom_range(99);
		if (live_offs.size() > 50 && sel < 40)
			sel += 40;
		if (sel < 40)
			q.mode = MODE_ALLOC;
		else if (sel < 62)
			q.mode = MODE_FREE;
		else if (sel < 70)
			q.mode = MODE_SHRINK;
		else if (sel < 73)
			q.mode = MODE_FREE_TYPE;
		else if (sel < 80)
			q.mode = MODE_MARK_STREAM;
		else if (sel < 86)
			q.mode = MODE_MARK_DONE;
		else
			q.mode = MODE_INSPECT;
		if (q.mode == MODE_FREE && live_offs.size() != 0 && q.off == live_offs[idx])
			live_offs.delete(idx);
		return q;
	endfunction

	// result side
	always @(posedge clk) begin
		heap_res_t want, got;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[17:0], m_tdata[35:18], m_tdata[36], m_tdata[55:37]};
			if (expected_q.size() == 0) begin
				$display("result with nothing outstanding");
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status)
					mismatch("status", got.status, want.status);
				if (got.roff !== want.roff)
					mismatch("result_offset", got.roff, want.roff);
				if (got.psize !== want.psize)
					mismatch("payload_size", got.psize, want.psize);
				if (got.rdy !== want.rdy)
					mismatch("block_ready", got.rdy, want.rdy);
				if (got.free !== want.free)
					mismatch("free_bytes", got.free, want.free);
			end
			checked_results++;
		end
		m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off so the block backs up its input
	initial begin
		hold_recv = 1'b0;
		wait (accepted_reqs >= 300);
		@(posedge clk);
		hold_recv <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_recv <= 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		heap_req_t q;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		accepted_reqs = 0;
		allocs_ok = 0;
		no_fits = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		heap_reset();

		add_typed(MODE_INSPECT, 0, 0, 8, STATUS_OK, 0, ARENA_BYTES - 8, 0, ARENA_BYTES);
		add_typed(MODE_INSPECT, 0, 0, 262143, STATUS_OK, 0, 0, 0, ARENA_BYTES);
		add_typed(MODE_ALLOC, 262144, 16, 0, STATUS_NOFIT_TOL, 0, 0, 0, ARENA_BYTES);
		add_typed(MODE_ALLOC, 262144, 255, 0, STATUS_NOFIT_FATAL, 0, 0, 0, ARENA_BYTES);
		add_typed(MODE_ALLOC, 0, 1, 0, STATUS_OK, 8, 0, 0, ARENA_BYTES - 8);
		add_row(MODE_ALLOC, 100, 7, 0);
		add_row(MODE_ALLOC, 3, 44, 0);
		add_row(MODE_ALLOC, 5, 47, 0);
		add_row(MODE_ALLOC, 1, 2, 0);
		add_row(MODE_ALLOC, 8, 4, 0);
		add_row(MODE_ALLOC, 64, 16, 0);
		add_row(MODE_MARK_STREAM, 0, 0, 262044);
		add_row(MODE_INSPECT, 0, 0, 262044);
		add_row(MODE_FREE_TYPE, 0, 7, 0);
		add_row(MODE_MARK_DONE, 0, 0, 262044);
		add_row(MODE_SHRINK, 16, 0, 262044);
		add_row(MODE_SHRINK, 7, 0, 262044);
		add_row(MODE_INSPECT, 0, 0, 262044);
		add_row(MODE_FREE, 0, 0, 262044);
		add_row(MODE_FREE, 0, 0, 262044);
		add_row(MODE_FREE, 0, 0, 4);
		add_row(MODE_MARK_STREAM, 0, 0, 8);
		add_row(MODE_FREE_TYPE, 0, 44, 0);
		add_row(MODE_ALLOC, 262136, 9, 0);
		add_row(MODE_FREE, 0, 0, 8);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_request(rows[i].r, rows[i].typed, rows[i].e);

		for (int n = 0; n < N_RANDOM; n++) begin
			case ((n / 283) % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 46; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			q = random_request();
			send_request(q, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;

		wait (expected_q.size() == 0);
		repeat (200) @(posedge clk);

		$display("%0d requests, %0d results checked: %0d allocations placed, %0d without fit",
			accepted_reqs, checked_results, allocs_ok, no_fits);
		$display("stall patterns: none, sender gaps, receiver stalls, both, plus a long hold");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/btha_pkg.sv
rtl/core/boundary_tag_heap_allocator.sv
rtl/core/btha_checker.sv
bench/tb_boundary_tag_heap_allocator.sv
